// ===== rtl/srtc_pkg.sv =====
// shared codes and types for the segment region table check block
// no dependencies; imported by the core and its checker
package srtc_pkg;

	// request codes carried on op
	localparam logic [1:0] OP_MAP   = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;
	localparam logic [1:0] OP_PATCH = 2'd3;

	// result codes carried on status
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_OVERLAP  = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_NOREGION = 3'd3;
	localparam logic [2:0] ST_NOWRITE  = 3'd4;
	localparam logic [2:0] ST_BOUNDS   = 3'd5;

	// sequencer states, one-hot
	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_OFFS  = 4'b0100,
		S_CHECK = 4'b1000
	} state_t;

endpackage

// ===== rtl/segment_region_table_check_core.sv =====
// region table with map, read lookup, write/fill and patch checks
// depends on srtc_pkg; checker attached by bind in srtc_checker.sv

// A request is taken when start is high and busy is low, and its single
// result beat shows on the result ports for one cycle with done high; the
// receiver cannot stall it. One compare unit walks the table one entry per
// cycle from the lowest index. A map request stops at the first entry it
// overlaps, else walks all stored regions and adds its own if there is
// room; a lookup stops at the first entry holding the address, else walks
// all stored regions, and on a hit goes on to form offset, then bound. A
// write/fill or patch check with a zero count answers in the next cycle.
// The table needs no clearing pass after reset: only entries below the
// region count are ever read. busy is low while the result beat shows, so
// the next request may start in that cycle.
module segment_region_table_check_core #(
	parameter int REGIONS   = 16,
	parameter int SIZE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [63:0] address,
	input  logic [31:0] length,
	input  logic        may_read,
	input  logic        may_write,
	input  logic        may_execute,
	output logic        done,
	output logic        ok,
	output logic [2:0]  status,
	output logic [3:0]  hit_index,
	output logic [31:0] region_offset,
	output logic [31:0] granted_count,
	output logic        hit_read,
	output logic        hit_write,
	output logic        hit_execute
);
	import srtc_pkg::*;

	localparam int CW = $clog2(REGIONS + 1);
	localparam int IW = (REGIONS > 1) ? $clog2(REGIONS) : 1;
	localparam int XW = (IW > 4) ? IW : 4;
	localparam int LW = (SIZE_BITS > 32) ? SIZE_BITS : 32;
	localparam logic [CW-1:0] FULL_COUNT = CW'(REGIONS);

	// region table memories
	logic [63:0]          base_mem [REGIONS];
	logic [SIZE_BITS-1:0] size_mem [REGIONS];
	logic [2:0]           perm_mem [REGIONS];

	state_t               state_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        rd_idx_q;
	logic                 rd_vld_s1;
	logic [IW-1:0]        rd_idx_s1;
	logic [63:0]          base_s1;
	logic [SIZE_BITS-1:0] size_s1;
	logic [2:0]           perm_s1;

	// captured request
	logic [1:0]           op_q;
	logic [63:0]          addr_q;
	logic [31:0]          len_q;
	logic [SIZE_BITS-1:0] new_size_q;
	logic [2:0]           new_perm_q;
	logic [64:0]          new_end_q;

	// matched region
	logic [IW-1:0]        hit_idx_q;
	logic [SIZE_BITS-1:0] hit_base_q;
	logic [SIZE_BITS-1:0] hit_size_q;
	logic [2:0]           hit_perm_q;
	logic [SIZE_BITS-1:0] off_q;

	// result beat
	logic                 done_q;
	logic                 ok_q;
	logic [2:0]           status_q;
	logic [3:0]           hit_index_q;
	logic [31:0]          offset_q;
	logic [31:0]          granted_q;
	logic [2:0]           perm_out_q;

	logic                 accept;
	logic [LW-1:0]        len_in_w;
	logic [SIZE_BITS-1:0] size_in;
	logic [64:0]          entry_end;
	logic                 overlap;
	logic                 holds;
	logic                 hit_cmp;
	logic                 hit_now;
	logic                 scan_end;
	logic                 map_write;
	logic [SIZE_BITS-1:0] avail;
	logic [LW-1:0]        avail_w;
	logic [LW-1:0]        len_w;
	logic [LW-1:0]        off_w;
	logic [XW-1:0]        idx_rd_w;
	logic [XW-1:0]        idx_hit_w;
	logic [XW-1:0]        idx_cnt_w;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	// size of a new region keeps the low SIZE_BITS bits of length
	assign len_in_w = LW'(length);
	assign size_in  = len_in_w[SIZE_BITS-1:0];

	// shared compare unit: entry end without wrap, then both bounds
	assign entry_end = {1'b0, base_s1} + 65'(size_s1);
	assign overlap   = ({1'b0, base_s1} < new_end_q) && ({1'b0, addr_q} < entry_end);
	assign holds     = (addr_q >= base_s1) && ({1'b0, addr_q} < entry_end);
	assign hit_cmp   = (op_q == OP_MAP) ? overlap : holds;
	assign hit_now   = (state_q == S_SCAN) && rd_vld_s1 && hit_cmp;
	assign scan_end  = (state_q == S_SCAN) && !hit_now && (rd_idx_q == count_q);
	assign map_write = scan_end && (op_q == OP_MAP) && (count_q < FULL_COUNT);

	// bytes left in the matched region
	assign avail   = hit_size_q - off_q;
	assign avail_w = LW'(avail);
	assign len_w   = LW'(len_q);
	assign off_w   = LW'(off_q);

	assign idx_rd_w  = XW'(rd_idx_s1);
	assign idx_hit_w = XW'(hit_idx_q);
	assign idx_cnt_w = XW'(count_q);

	// table write and registered table read
	always_ff @(posedge clk) begin
		if (map_write) begin
			base_mem[count_q[IW-1:0]] <= addr_q;
			size_mem[count_q[IW-1:0]] <= new_size_q;
			perm_mem[count_q[IW-1:0]] <= new_perm_q;
		end
		base_s1 <= base_mem[rd_idx_q[IW-1:0]];
		size_s1 <= size_mem[rd_idx_q[IW-1:0]];
		perm_s1 <= perm_mem[rd_idx_q[IW-1:0]];
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q    <= 1'b0;
			rd_vld_s1 <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					rd_idx_q <= '0;
					if (accept) begin
						if (op != OP_MAP && op != OP_READ && length == 32'd0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (hit_now) begin
						if (op_q == OP_MAP) begin
							state_q <= S_IDLE;
							done_q  <= 1'b1;
						end else begin
							state_q <= S_OFFS;
						end
					end else if (scan_end) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						if (map_write) begin
							count_q <= count_q + CW'(1);
						end
					end else begin
						rd_idx_q  <= rd_idx_q + CW'(1);
						rd_vld_s1 <= 1'b1;
					end
				end
				S_OFFS: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request capture, hit capture and result payload
	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_idx_q[IW-1:0];
		if (accept) begin
			op_q       <= op;
			addr_q     <= address;
			len_q      <= length;
			new_size_q <= size_in;
			new_perm_q <= {may_execute, may_write, may_read};
			new_end_q  <= {1'b0, address} + 65'(size_in);
			// zero-count write/fill or patch answers at once
			ok_q        <= 1'b1;
			status_q    <= ST_OK;
			hit_index_q <= '0;
			offset_q    <= '0;
			granted_q   <= '0;
			perm_out_q  <= '0;
		end
		if (hit_now) begin
			hit_idx_q  <= rd_idx_s1;
			hit_base_q <= base_s1[SIZE_BITS-1:0];
			hit_size_q <= size_s1;
			hit_perm_q <= perm_s1;
			if (op_q == OP_MAP) begin
				ok_q        <= 1'b0;
				status_q    <= ST_OVERLAP;
				hit_index_q <= idx_rd_w[3:0];
				offset_q    <= '0;
				granted_q   <= '0;
				perm_out_q  <= '0;
			end
		end
		if (scan_end) begin
			offset_q  <= '0;
			granted_q <= '0;
			if (op_q != OP_MAP) begin
				ok_q        <= 1'b0;
				status_q    <= ST_NOREGION;
				hit_index_q <= '0;
				perm_out_q  <= '0;
			end else if (map_write) begin
				ok_q        <= 1'b1;
				status_q    <= ST_OK;
				hit_index_q <= idx_cnt_w[3:0];
				perm_out_q  <= new_perm_q;
			end else begin
				ok_q        <= 1'b0;
				status_q    <= ST_FULL;
				hit_index_q <= '0;
				perm_out_q  <= '0;
			end
		end
		// offset fits in SIZE_BITS since it stays below the region size
		if (state_q == S_OFFS) begin
			off_q <= addr_q[SIZE_BITS-1:0] - hit_base_q;
		end
		if (state_q == S_CHECK) begin
			hit_index_q <= idx_hit_w[3:0];
			offset_q    <= off_w[31:0];
			perm_out_q  <= hit_perm_q;
			if (op_q == OP_READ) begin
				ok_q      <= 1'b1;
				status_q  <= ST_OK;
				granted_q <= (len_w < avail_w) ? len_q : avail_w[31:0];
			end else if (op_q == OP_WRITE && !hit_perm_q[1]) begin
				ok_q      <= 1'b0;
				status_q  <= ST_NOWRITE;
				granted_q <= '0;
			end else if (len_w > avail_w) begin
				ok_q      <= 1'b0;
				status_q  <= ST_BOUNDS;
				granted_q <= '0;
			end else begin
				ok_q      <= 1'b1;
				status_q  <= ST_OK;
				granted_q <= len_q;
			end
		end
	end

	assign done          = done_q;
	assign ok            = ok_q;
	assign status        = status_q;
	assign hit_index     = hit_index_q;
	assign region_offset = offset_q;
	assign granted_count = granted_q;
	assign hit_read      = perm_out_q[0];
	assign hit_write     = perm_out_q[1];
	assign hit_execute   = perm_out_q[2];

endmodule

// ===== rtl/srtc_checker.sv =====
// port-level checks for the segment region table check core
// depends on srtc_pkg; bound to segment_region_table_check_core below
module srtc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [1:0]  op,
	input logic [31:0] length,
	input logic        done,
	input logic        ok,
	input logic [2:0]  status,
	input logic [31:0] granted_count
);
	import srtc_pkg::*;

	// ok flag agrees with the status code on every result beat
	a_ok_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (ok == (status == ST_OK)))
		else $error("ok and status disagree");

	// a failed request grants no bytes
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !ok) |-> (granted_count == 32'd0))
		else $error("failed request granted bytes");

	// a result beat only shows once the block is free again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	// zero-count write/fill or patch answers in the next cycle
	a_zero_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (op == OP_WRITE || op == OP_PATCH) && length == 32'd0)
		|=> (done && ok && !busy))
		else $error("zero-count check did not answer at once");

	// map and read requests walk the table
	a_scan_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (op == OP_MAP || op == OP_READ)) |=> busy)
		else $error("table walk did not start");

endmodule

bind segment_region_table_check_core srtc_checker u_srtc_checker (.*);

// ===== tb/segment_region_table_check_core_tb.sv =====
`timescale 1ns / 100ps
// testbench for segment_region_table_check_core: directed and random map, read,
// write/fill and patch requests checked against a region table predictor held here
// depends on srtc_pkg and the core rtl

module segment_region_table_check_core_tb;
	import srtc_pkg::*;

	localparam int TABLE_DEPTH     = 16;
	localparam int RANDOM_REQUESTS = 400;
	localparam int PHASE_LEN       = 142;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int TAIL_CYCLES     = 40;

	typedef struct packed {
		logic [1:0]  op;
		logic [63:0] address;
		logic [31:0] length;
		logic        may_read;
		logic        may_write;
		logic        may_execute;
	} request_t;

	typedef struct {
		request_t rq;
		int       idle_pct;
		bit       drain;
	} queued_t;

	typedef struct packed {
		logic        ok;
		logic [2:0]  status;
		logic [3:0]  hit_index;
		logic [31:0] region_offset;
		logic [31:0] granted_count;
		logic        hit_read;
		logic        hit_write;
		logic        hit_execute;
	} verdict_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	request_t cur_req = '0;

	logic        busy, done, ok, hit_read, hit_write, hit_execute;
	logic [2:0]  status;
	logic [3:0]  hit_index;
	logic [31:0] region_offset, granted_count;

	queued_t  queued_requests[$];
	verdict_t expected_verdicts[$];
	logic [63:0] plan_base[$];
	logic [31:0] plan_size[$];

	// predicted region table
	logic [63:0] tbl_base [TABLE_DEPTH];
	logic [31:0] tbl_size [TABLE_DEPTH];
	logic [2:0]  tbl_perm [TABLE_DEPTH];
	int          tbl_count = 0;

	int issued_cnt = 0;
	int accepted_cnt = 0;
	int cycle_cnt = 0;
	int mismatch_cnt = 0;
	int made_cnt = 0;
	int op_cnt [4] = '{default: 0};
	int status_cnt [8] = '{default: 0};

	segment_region_table_check_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.op            (cur_req.op),
		.address       (cur_req.address),
		.length        (cur_req.length),
		.may_read      (cur_req.may_read),
		.may_write     (cur_req.may_write),
		.may_execute   (cur_req.may_execute),
		.done          (done),
		.ok            (ok),
		.status        (status),
		.hit_index     (hit_index),
		.region_offset (region_offset),
		.granted_count (granted_count),
		.hit_read      (hit_read),
		.hit_write     (hit_write),
		.hit_execute   (hit_execute)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// x lies below base + size, the sum taken without wrap
	function automatic bit below_region_end(logic [63:0] x, logic [63:0] base,
			logic [31:0] size);
		logic [63:0] gap;
		gap = x - base;
		return (x < base) || (gap < {32'd0, size});
	endfunction

	// apply one request to the predicted table and return its result beat
	function automatic verdict_t judge_request(request_t rq);
		verdict_t    v;
		logic [63:0] offs;
		logic [31:0] room;
		int          i;
		v = '0;
		if (rq.op == OP_MAP) begin
			for (i = 0; i < tbl_count; i++) begin
				if (below_region_end(tbl_base[i], rq.address, rq.length) &&
						below_region_end(rq.address, tbl_base[i], tbl_size[i])) begin
					v.status = ST_OVERLAP;
					v.hit_index = 4'(i);
					return v;
				end
			end
			if (tbl_count >= TABLE_DEPTH) begin
				v.status = ST_FULL;
				return v;
			end
			tbl_base[tbl_count] = rq.address;
			tbl_size[tbl_count] = rq.length;
			tbl_perm[tbl_count] = {rq.may_execute, rq.may_write, rq.may_read};
			v.ok = 1'b1;
			v.status = ST_OK;
			v.hit_index = 4'(tbl_count);
			v.hit_read = rq.may_read;
			v.hit_write = rq.may_write;
			v.hit_execute = rq.may_execute;
			tbl_count++;
			return v;
		end
		// zero-count write/fill and patch succeed without a lookup
		if (rq.op != OP_READ && rq.length == 32'd0) begin
			v.ok = 1'b1;
			v.status = ST_OK;
			return v;
		end
		for (i = 0; i < tbl_count; i++) begin
			if (rq.address >= tbl_base[i] &&
					(rq.address - tbl_base[i]) < {32'd0, tbl_size[i]})
				break;
		end
		if (i >= tbl_count) begin
			v.status = ST_NOREGION;
			return v;
		end
		offs = rq.address - tbl_base[i];
		room = tbl_size[i] - offs[31:0];
		v.hit_index = 4'(i);
		v.region_offset = offs[31:0];
		v.hit_read = tbl_perm[i][0];
		v.hit_write = tbl_perm[i][1];
		v.hit_execute = tbl_perm[i][2];
		if (rq.op == OP_READ) begin
			v.ok = 1'b1;
			v.status = ST_OK;
			v.granted_count = (rq.length < room) ? rq.length : room;
		end else if (rq.op == OP_WRITE && !tbl_perm[i][1]) begin
			v.status = ST_NOWRITE;
		end else if (rq.length > room) begin
			v.status = ST_BOUNDS;
		end else begin
			v.ok = 1'b1;
			v.status = ST_OK;
			v.granted_count = rq.length;
		end
		return v;
	endfunction

	task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			mismatch_cnt++;
			$display("%0t: %s expected %0h, got %0h", $time, field, want, got);
		end
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// queue one request; idle rate follows the phase of the run
	task automatic queue_request(logic [1:0] req_op, logic [63:0] address,
			logic [31:0] length, logic [2:0] perm);
		queued_t q;
		q.rq.op = req_op;
		q.rq.address = address;
		q.rq.length = length;
		q.rq.may_read = perm[0];
		q.rq.may_write = perm[1];
		q.rq.may_execute = perm[2];
		if (made_cnt < PHASE_LEN)
			q.idle_pct = 29;
		else if (made_cnt < 2 * PHASE_LEN)
			q.idle_pct = 70;
		else
			q.idle_pct = 0;
		q.drain = (made_cnt % 45 == 44);
		if (req_op == OP_MAP) begin
			plan_base.insert(plan_base.size(), address);
			plan_size.insert(plan_size.size(), length);
		end
		queued_requests.insert(queued_requests.size(), q);
		made_cnt++;
	endtask

	// driver: next request beat at the falling edge once the last one was taken
	always @(negedge clk) begin
		queued_t nxt;
		if (arst_n && (!start || accepted_cnt == issued_cnt)) begin
			if (queued_requests.size() != 0 &&
					!(queued_requests[0].drain && expected_verdicts.size() != 0) &&
					$urandom_range(99) >= queued_requests[0].idle_pct) begin
				nxt = queued_requests.pop_front();
				cur_req <= nxt.rq;
				start <= 1'b1;
				issued_cnt++;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: check result beats, predict accepted request beats
	always @(posedge clk) begin
		verdict_t want;
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
			$display("Mismatches found");
			$finish;
		end else if (arst_n) begin
			if (done) begin
				if (expected_verdicts.size() == 0) begin
					mismatch_cnt++;
					$display("%0t: result beat with no request waiting, status %0d",
						$time, status);
				end else begin
					want = expected_verdicts.pop_front();
					check_field("ok", 64'(want.ok), 64'(ok));
					check_field("status", 64'(want.status), 64'(status));
					check_field("hit_index", 64'(want.hit_index), 64'(hit_index));
					check_field("region_offset", 64'(want.region_offset),
						64'(region_offset));
					check_field("granted_count", 64'(want.granted_count),
						64'(granted_count));
					check_field("hit_read", 64'(want.hit_read), 64'(hit_read));
					check_field("hit_write", 64'(want.hit_write), 64'(hit_write));
					check_field("hit_execute", 64'(want.hit_execute), 64'(hit_execute));
					status_cnt[status]++;
				end
			end
			if (start && !busy) begin
				expected_verdicts.insert(expected_verdicts.size(), judge_request(cur_req));
				op_cnt[cur_req.op]++;
				accepted_cnt++;
			end
		end
	end

	initial begin
		logic [1:0]  req_op;
		logic [63:0] base, offs;
		logic [31:0] size, room, len;
		int          pick, k, n;

		// directed: empty table, boundaries, zero sizes, top of address space
		queue_request(OP_READ,  64'h0, 32'd1, 3'b000);
		queue_request(OP_WRITE, 64'h1000, 32'd0, 3'b000);
		queue_request(OP_MAP,   64'h1000, 32'h100, 3'b001);
		queue_request(OP_MAP,   64'h1080, 32'h10, 3'b111);
		queue_request(OP_MAP,   64'h10FF, 32'd0, 3'b010);
		queue_request(OP_MAP,   64'h1100, 32'd0, 3'b110);
		queue_request(OP_READ,  64'h1100, 32'd5, 3'b000);
		queue_request(OP_MAP,   64'hFFFF_FFFF_FFFF_FF00, 32'hFFFF_FFFF, 3'b111);
		queue_request(OP_MAP,   64'h0, 32'h10, 3'b010);
		queue_request(OP_READ,  64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 3'b111);
		queue_request(OP_WRITE, 64'h1010, 32'd4, 3'b000);
		queue_request(OP_PATCH, 64'h1010, 32'hF0, 3'b000);
		queue_request(OP_PATCH, 64'h1010, 32'hF1, 3'b000);
		queue_request(OP_WRITE, 64'h0, 32'h10, 3'b000);
		queue_request(OP_WRITE, 64'h8, 32'h9, 3'b000);
		queue_request(OP_READ,  64'h1000, 32'd0, 3'b000);
		queue_request(OP_PATCH, 64'h5555_AAAA_5555_AAAA, 32'd0, 3'b111);
		queue_request(OP_READ,  64'h0FFF, 32'd1, 3'b000);
		queue_request(OP_MAP,   64'h2000_0000, 32'hFFFF_FFFF, 3'b100);
		queue_request(OP_MAP,   64'h8000_0000_0000_0000, 32'h8000_0000, 3'b101);
		queue_request(OP_READ,  64'h8000_0000_7FFF_FFFF, 32'd16, 3'b000);
		queue_request(OP_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1, 3'b000);
		queue_request(OP_READ,  64'h1_1FFF_FFFF, 32'hFFFF_FFFF, 3'b000);
		queue_request(OP_WRITE, 64'h2000_0000, 32'd1, 3'b000);

		// random: maps mixed with mostly accesses near planned regions
		for (n = 0; n < RANDOM_REQUESTS; n++) begin
			pick = $urandom_range(99);
			k = $urandom_range(plan_base.size() - 1);
			if (pick < 15) begin
				case ($urandom_range(3))
					0, 1: base = rand64();
					2: base = plan_base[k] + plan_size[k];
					default: base = plan_base[k] + 64'($urandom_range(512)) - 64'd256;
				endcase
				case ($urandom_range(4))
					0: size = $urandom_range(4096, 1);
					1: size = $urandom;
					2: size = 32'd0;
					3: size = 32'hFFFF_FFFF;
					default: size = $urandom_range(256, 1);
				endcase
				queue_request(OP_MAP, base, size, 3'($urandom));
			end else begin
				req_op = (pick < 50) ? OP_READ : (pick < 75) ? OP_WRITE : OP_PATCH;
				base = plan_base[k];
				size = plan_size[k];
				case ($urandom_range(7))
					0: offs = 64'd0;
					1: offs = {32'd0, size} - 64'd1;
					2: offs = {32'd0, size};
					3: offs = 64'hFFFF_FFFF_FFFF_FFFF;
					4, 5: offs = (size == 32'd0) ? 64'd0 : {32'd0, $urandom % size};
					default: offs = rand64() - base;
				endcase
				room = size - offs[31:0];
				case ($urandom_range(9))
					0: len = 32'd0;
					1: len = 32'hFFFF_FFFF;
					2: len = $urandom;
					3, 4: len = room;
					5: len = room + 32'd1;
					default: len = $urandom_range(64, 1);
				endcase
				queue_request(req_op, base + offs, len, 3'($urandom));
			end
		end

		// reset once, released on a falling edge
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// wait for the last beat, then let the block settle
		while (queued_requests.size() != 0 || accepted_cnt != issued_cnt ||
				expected_verdicts.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (expected_verdicts.size() != 0)
			$display("%0t: %0d expected result beats never arrived", $time,
				expected_verdicts.size());
		$display("covered %0d requests: %0d maps, %0d reads, %0d write/fill, %0d patch",
			accepted_cnt, op_cnt[OP_MAP], op_cnt[OP_READ], op_cnt[OP_WRITE],
			op_cnt[OP_PATCH]);
		$display("outcomes: ok %0d, overlap %0d, full %0d, no region %0d, %0s %0d, %0s %0d",
			status_cnt[ST_OK], status_cnt[ST_OVERLAP], status_cnt[ST_FULL],
			status_cnt[ST_NOREGION], "not writable", status_cnt[ST_NOWRITE],
			"out of bounds", status_cnt[ST_BOUNDS]);
		if (mismatch_cnt == 0 && expected_verdicts.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
